FILE: rtl/pi_drive_with_relay_modes_core_macros.svh
// ---------------------------------------------------------------------------
// pi_drive_with_relay_modes_core_macros
// Assertion macros shared by the checkers of the drive controller.
// ---------------------------------------------------------------------------
`ifndef PI_DRIVE_WITH_RELAY_MODES_CORE_MACROS_SVH
`define PI_DRIVE_WITH_RELAY_MODES_CORE_MACROS_SVH

// same-cycle implication on the rising clock edge
`define PDR_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pdr_checker: same-cycle property failed");

// next-cycle implication on the rising clock edge
`define PDR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pdr_checker: next-cycle property failed");

`endif

FILE: rtl/pdr_pkg.sv
// ---------------------------------------------------------------------------
// pdr_pkg
// Shared constants and types of the two-channel drive controller.
// ---------------------------------------------------------------------------
package pdr_pkg;

    localparam int unsigned FULL_DRIVE_DEF = 250;

    localparam int unsigned ERR_W   = 16;
    localparam int unsigned GAIN_W  = 8;
    localparam int unsigned DRIVE_W = 8;
    localparam int unsigned FRAC_W  = 16;
    // |err| * gain
    localparam int unsigned PROD_W  = ERR_W + GAIN_W;
    // divisor * 10, divisor up to 255
    localparam int unsigned DSR_W   = 12;
    localparam int unsigned ADDR_W  = 5;
    localparam int unsigned DATA_W  = 32;

    typedef enum logic [2:0] {
        REG_RELAY_MODE  = 3'd0,
        REG_HUM_HYST    = 3'd1,
        REG_P_GAIN_HEAT = 3'd2,
        REG_I_DIV_HEAT  = 3'd3,
        REG_P_GAIN_HUM  = 3'd4,
        REG_I_DIV_HUM   = 3'd5
    } pdr_reg_t;

endpackage

FILE: rtl/pi_drive_with_relay_modes_core.sv
// ---------------------------------------------------------------------------
// pi_drive_with_relay_modes_core
// Two-channel PI drive controller with anti-windup clamp and relay modes.
// ---------------------------------------------------------------------------
// Input channel s_*: one item per control update, s_tdata = err (signed),
// s_tuser = channel (0 heater, 1 humidifier). Output channel m_*: one item
// per input, m_tdata = drive level 0 .. FULL_DRIVE (low 8 bits).
// APB port: six registers at byte addresses 0,4,..,20. The user must write
// them only while the block is idle; the block does not enforce this.
// pready is tied high. A relay-mode item goes from acceptance to the output
// register through the done state. A PI item runs a bit-serial multiply over
// the gain bits, a restoring division one quotient bit a cycle, then the
// accumulate, clamp and integral write-back steps and the output load.
// One item is in work at a time; the next one is taken in the cycle after the
// result is loaded into the output register, so the block does not take a
// new item before it is through with the last one.
// Reset clears both integrals, the humidifier latch and the registers
// (divisors to 1). If the receiver stalls, the result holds in the output
// register while the next item is computed; that item then waits for the
// output register to free up.
// ---------------------------------------------------------------------------
module pi_drive_with_relay_modes_core #(
    parameter int unsigned FULL_DRIVE = pdr_pkg::FULL_DRIVE_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [pdr_pkg::ERR_W-1:0]       s_tdata,   // [15:0] err
    input  logic                            s_tuser,   // [0] channel
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [pdr_pkg::DRIVE_W-1:0]     m_tdata,   // [7:0] drive
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [pdr_pkg::ADDR_W-1:0]      paddr,
    input  logic [pdr_pkg::DATA_W-1:0]      pwdata,
    output logic [pdr_pkg::DATA_W-1:0]      prdata,
    output logic                            pready
);

    localparam int unsigned FULL_W = $clog2(FULL_DRIVE + 1);
    localparam int unsigned FRAC_W = pdr_pkg::FRAC_W;
    localparam int unsigned PROD_W = pdr_pkg::PROD_W;
    localparam int unsigned DSR_W  = pdr_pkg::DSR_W;
    localparam int unsigned DVD_W  = PROD_W + FRAC_W;
    localparam int unsigned INT_W  = FULL_W + FRAC_W + 2;
    localparam int unsigned SUM_W  = ((DVD_W + 1 > INT_W) ? DVD_W + 1 : INT_W) + 2;
    localparam int unsigned CNT_W  = $clog2(DVD_W + 1);
    localparam int unsigned GAIN_W = pdr_pkg::GAIN_W;
    localparam int unsigned ERR_W  = pdr_pkg::ERR_W;
    localparam int unsigned DRV_W  = pdr_pkg::DRIVE_W;

    localparam logic [SUM_W-1:0]  TOP       = SUM_W'(FULL_DRIVE) << FRAC_W;
    localparam logic [DRV_W-1:0]  FULL8     = DRV_W'(FULL_DRIVE);
    localparam logic [CNT_W-1:0]  MUL_LAST  = CNT_W'(GAIN_W - 1);
    localparam logic [CNT_W-1:0]  DIV_LAST  = CNT_W'(DVD_W - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_SUM_P,
        ST_SUM_I,
        ST_CLAMP,
        ST_WB,
        ST_DONE
    } state_t;

    // control and configuration
    state_t                   state_reg, state_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic                     m_tvalid_reg, m_tvalid_next;
    logic [DRV_W-1:0]         m_tdata_reg, m_tdata_next;
    logic [1:0]               relay_mode_reg, relay_mode_next;
    logic [1:0]               hum_hyst_reg, hum_hyst_next;
    logic [GAIN_W-1:0]        p_gain_heat_reg, p_gain_heat_next;
    logic [GAIN_W-1:0]        i_div_heat_reg, i_div_heat_next;
    logic [GAIN_W-1:0]        p_gain_hum_reg, p_gain_hum_next;
    logic [GAIN_W-1:0]        i_div_hum_reg, i_div_hum_next;
    logic signed [INT_W-1:0]  integral_reg [2];
    logic signed [INT_W-1:0]  integral_next [2];
    logic                     hum_latch_reg, hum_latch_next;

    // datapath
    logic                     ch_reg, ch_next;
    logic                     neg_reg, neg_next;
    logic [ERR_W-1:0]         mag_reg, mag_next;
    logic [GAIN_W-1:0]        gain_sh_reg, gain_sh_next;
    logic [PROD_W-1:0]        prod_reg, prod_next;
    logic [DVD_W-1:0]         dvd_reg, dvd_next;
    logic [DSR_W-1:0]         rem_reg, rem_next;
    logic [FULL_W-1:0]        p_reg, p_next;
    logic signed [SUM_W-1:0]  acc_reg, acc_next;
    logic [DRV_W-1:0]         drive_reg, drive_next;

    logic                     accept_in;
    logic                     cfg_wr;
    logic                     relay_sel;
    logic [GAIN_W-1:0]        div_sel;
    logic [GAIN_W-1:0]        div_eff;
    logic [DSR_W-1:0]         dsr;
    logic [DSR_W:0]           rem_sh;
    logic                     q_bit;
    logic [PROD_W-1:0]        prod_step;
    logic signed [SUM_W-1:0]  p_scaled;
    logic signed [SUM_W-1:0]  quot_ext;

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept_in = s_tvalid && s_tready;
    assign cfg_wr    = psel && penable && pwrite;
    assign pready    = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    assign relay_sel = s_tuser ? relay_mode_reg[1] : relay_mode_reg[0];
    assign div_sel   = ch_reg ? i_div_hum_reg : i_div_heat_reg;
    assign div_eff   = (div_sel == '0) ? GAIN_W'(1) : div_sel;
    // divisor * 10 as two shifts and an add
    assign dsr       = (DSR_W'(div_eff) << 3) + (DSR_W'(div_eff) << 1);

    assign rem_sh    = {rem_reg, dvd_reg[DVD_W-1]};
    assign q_bit     = (rem_sh >= {1'b0, dsr});
    assign prod_step = {prod_reg[PROD_W-2:0], 1'b0}
                     + (gain_sh_reg[GAIN_W-1] ? PROD_W'(mag_reg) : PROD_W'(0));
    assign p_scaled  = $signed(SUM_W'(p_reg) << FRAC_W);
    assign quot_ext  = $signed(SUM_W'(dvd_reg));

    always_comb
    begin
        prdata = '0;
        unique case (pdr_pkg::pdr_reg_t'(paddr[4:2]))
            pdr_pkg::REG_RELAY_MODE:  prdata = pdr_pkg::DATA_W'(relay_mode_reg);
            pdr_pkg::REG_HUM_HYST:    prdata = pdr_pkg::DATA_W'(hum_hyst_reg);
            pdr_pkg::REG_P_GAIN_HEAT: prdata = pdr_pkg::DATA_W'(p_gain_heat_reg);
            pdr_pkg::REG_I_DIV_HEAT:  prdata = pdr_pkg::DATA_W'(i_div_heat_reg);
            pdr_pkg::REG_P_GAIN_HUM:  prdata = pdr_pkg::DATA_W'(p_gain_hum_reg);
            pdr_pkg::REG_I_DIV_HUM:   prdata = pdr_pkg::DATA_W'(i_div_hum_reg);
            default:                  prdata = '0;
        endcase
    end

    always_comb
    begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        m_tvalid_next    = m_tvalid_reg;
        m_tdata_next     = m_tdata_reg;
        relay_mode_next  = relay_mode_reg;
        hum_hyst_next    = hum_hyst_reg;
        p_gain_heat_next = p_gain_heat_reg;
        i_div_heat_next  = i_div_heat_reg;
        p_gain_hum_next  = p_gain_hum_reg;
        i_div_hum_next   = i_div_hum_reg;
        integral_next    = integral_reg;
        hum_latch_next   = hum_latch_reg;
        ch_next          = ch_reg;
        neg_next         = neg_reg;
        mag_next         = mag_reg;
        gain_sh_next     = gain_sh_reg;
        prod_next        = prod_reg;
        dvd_next         = dvd_reg;
        rem_next         = rem_reg;
        p_next           = p_reg;
        acc_next         = acc_reg;
        drive_next       = drive_reg;

        if (cfg_wr)
        begin
            unique case (pdr_pkg::pdr_reg_t'(paddr[4:2]))
                pdr_pkg::REG_RELAY_MODE:  relay_mode_next  = pwdata[1:0];
                pdr_pkg::REG_HUM_HYST:    hum_hyst_next    = pwdata[1:0];
                pdr_pkg::REG_P_GAIN_HEAT: p_gain_heat_next = pwdata[GAIN_W-1:0];
                pdr_pkg::REG_I_DIV_HEAT:  i_div_heat_next  = pwdata[GAIN_W-1:0];
                pdr_pkg::REG_P_GAIN_HUM:  p_gain_hum_next  = pwdata[GAIN_W-1:0];
                pdr_pkg::REG_I_DIV_HUM:   i_div_hum_next   = pwdata[GAIN_W-1:0];
                default:                  ;
            endcase
        end

        // drop the output item once taken
        if (m_tvalid_reg && m_tready)
            m_tvalid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept_in)
                begin
                    ch_next      = s_tuser;
                    neg_next     = s_tdata[ERR_W-1];
                    mag_next     = s_tdata[ERR_W-1] ? ERR_W'(-s_tdata) : s_tdata;
                    gain_sh_next = s_tuser ? p_gain_hum_reg : p_gain_heat_reg;
                    prod_next    = '0;
                    cnt_next     = '0;
                    if (relay_sel)
                    begin
                        state_next = ST_DONE;
                        if (!s_tuser)
                        begin
                            drive_next = (!s_tdata[ERR_W-1] && (s_tdata != '0))
                                       ? FULL8 : '0;
                        end
                        else if (!s_tdata[ERR_W-1] && (s_tdata > ERR_W'(hum_hyst_reg)))
                        begin
                            hum_latch_next = 1'b1;
                            drive_next     = FULL8;
                        end
                        else if (s_tdata[ERR_W-1])
                        begin
                            hum_latch_next = 1'b0;
                            drive_next     = '0;
                        end
                        else
                        begin
                            // inside the hysteresis band: hold the latch
                            drive_next = hum_latch_reg ? FULL8 : '0;
                        end
                    end
                    else
                    begin
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL:
            begin
                prod_next    = prod_step;
                gain_sh_next = {gain_sh_reg[GAIN_W-2:0], 1'b0};
                cnt_next     = cnt_reg + CNT_W'(1);
                if (cnt_reg == MUL_LAST)
                begin
                    dvd_next   = {prod_step, FRAC_W'(0)};
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                rem_next = q_bit ? DSR_W'(rem_sh - {1'b0, dsr}) : rem_sh[DSR_W-1:0];
                dvd_next = {dvd_reg[DVD_W-2:0], q_bit};
                cnt_next = cnt_reg + CNT_W'(1);
                // proportional part, clamped to [0, FULL_DRIVE]
                if (neg_reg)
                    p_next = '0;
                else if (prod_reg > PROD_W'(FULL_DRIVE))
                    p_next = FULL_W'(FULL_DRIVE);
                else
                    p_next = prod_reg[FULL_W-1:0];
                if (cnt_reg == DIV_LAST)
                    state_next = ST_SUM_P;
            end
            ST_SUM_P:
            begin
                acc_next   = p_scaled + SUM_W'(integral_reg[ch_reg]);
                state_next = ST_SUM_I;
            end
            ST_SUM_I:
            begin
                acc_next   = neg_reg ? (acc_reg - quot_ext) : (acc_reg + quot_ext);
                state_next = ST_CLAMP;
            end
            ST_CLAMP:
            begin
                if (acc_reg < 0)
                    acc_next = '0;
                else if (acc_reg > $signed(TOP))
                    acc_next = $signed(TOP);
                state_next = ST_WB;
            end
            ST_WB:
            begin
                // back-calculate the integral from the clamped sum
                integral_next[ch_reg] = INT_W'(acc_reg - p_scaled);
                drive_next            = acc_reg[FRAC_W +: DRV_W];
                state_next            = ST_DONE;
            end
            ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = drive_reg;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            cnt_reg         <= '0;
            m_tvalid_reg    <= 1'b0;
            m_tdata_reg     <= '0;
            relay_mode_reg  <= '0;
            hum_hyst_reg    <= '0;
            p_gain_heat_reg <= '0;
            i_div_heat_reg  <= GAIN_W'(1);
            p_gain_hum_reg  <= '0;
            i_div_hum_reg   <= GAIN_W'(1);
            integral_reg[0] <= '0;
            integral_reg[1] <= '0;
            hum_latch_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            cnt_reg         <= cnt_next;
            m_tvalid_reg    <= m_tvalid_next;
            m_tdata_reg     <= m_tdata_next;
            relay_mode_reg  <= relay_mode_next;
            hum_hyst_reg    <= hum_hyst_next;
            p_gain_heat_reg <= p_gain_heat_next;
            i_div_heat_reg  <= i_div_heat_next;
            p_gain_hum_reg  <= p_gain_hum_next;
            i_div_hum_reg   <= i_div_hum_next;
            integral_reg[0] <= integral_next[0];
            integral_reg[1] <= integral_next[1];
            hum_latch_reg   <= hum_latch_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg      <= ch_next;
        neg_reg     <= neg_next;
        mag_reg     <= mag_next;
        gain_sh_reg <= gain_sh_next;
        prod_reg    <= prod_next;
        dvd_reg     <= dvd_next;
        rem_reg     <= rem_next;
        p_reg       <= p_next;
        acc_reg     <= acc_next;
        drive_reg   <= drive_next;
    end

endmodule

FILE: rtl/pdr_checker.sv
// ---------------------------------------------------------------------------
// pdr_checker
// Port-level checks of the drive controller, bound to the top level.
// ---------------------------------------------------------------------------
`include "pi_drive_with_relay_modes_core_macros.svh"

module pdr_checker #(
    parameter int unsigned FULL_DRIVE = pdr_pkg::FULL_DRIVE_DEF
) (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [pdr_pkg::DRIVE_W-1:0]     m_tdata
);

    // a stalled result holds
    `PDR_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // the drive never exceeds full scale
    `PDR_ASSERT_IMPL(a_drive_range, m_tvalid, (FULL_DRIVE > 255) || (m_tdata <= FULL_DRIVE))

    // one item at a time: busy right after an accept
    `PDR_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)

    // no result appears in the cycle right after an accept
    `PDR_ASSERT_NEXT(a_no_early_result, s_tvalid && s_tready, !$rose(m_tvalid))

endmodule

bind pi_drive_with_relay_modes_core pdr_checker #(.FULL_DRIVE(FULL_DRIVE)) u_pdr_checker (.*);

FILE: dv/pi_drive_with_relay_modes_core_tb.sv
// ---------------------------------------------------------------------------
// pi_drive_with_relay_modes_core_tb
// Self-checking testbench for the two-channel PI / relay drive controller.
// A directed table runs first: reset behavior, relay extremes, the humidifier
// hysteresis band and PI saturation. Random phases follow, each with a fresh
// register setting. Each drive item is checked against a typed-in value or an
// in-bench model of the integrals, the humidifier latch and the clamp logic.
// ---------------------------------------------------------------------------
module pi_drive_with_relay_modes_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned FULL = pdr_pkg::FULL_DRIVE_DEF;
    localparam logic [2:0]  REG_UNMAPPED = 3'd6;
    localparam int          PHASES = 8;
    localparam int          ITEMS_PER_PHASE = 50;
    localparam int          END_WAIT = 64;

    typedef struct packed {
        logic        cfg;    // 1: register write, 0: input item
        logic [2:0]  idx;
        logic [7:0]  val;
        logic        ch;
        logic [15:0] err;
        logic        known;  // drive value typed in below
        logic [7:0]  drive;
    } step_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         s_tvalid = 1'b0;
    logic                         s_tready;
    logic [pdr_pkg::ERR_W-1:0]    s_tdata = '0;   // [15:0] err
    logic                         s_tuser = 1'b0; // [0] channel
    logic                         m_tvalid;
    logic                         m_tready = 1'b0;
    logic [pdr_pkg::DRIVE_W-1:0]  m_tdata;        // [7:0] drive
    logic                         psel = 1'b0;
    logic                         penable = 1'b0;
    logic                         pwrite = 1'b0;
    logic [pdr_pkg::ADDR_W-1:0]   paddr = '0;
    logic [pdr_pkg::DATA_W-1:0]   pwdata = '0;
    logic [pdr_pkg::DATA_W-1:0]   prdata;
    logic                         pready;

    // model copy of registers and state
    logic [1:0]  relay_mode;
    logic [1:0]  hum_hyst;
    logic [7:0]  gain_heat;
    logic [7:0]  div_heat;
    logic [7:0]  gain_hum;
    logic [7:0]  div_hum;
    longint      integ [2];
    logic        hum_latch;

    logic [7:0]  expected_drive_q [$];
    int          errors = 0;
    bit          src_idle = 1'b1;
    bit          snk_idle = 1'b1;

    step_t directed_steps [34] = '{
        // after reset all gains are zero
        '{1'b0, 3'd0, 8'd0, 1'b0, 16'h7FFF, 1'b1, 8'd0},
        '{1'b0, 3'd0, 8'd0, 1'b1, 16'h8000, 1'b1, 8'd0},
        '{1'b0, 3'd0, 8'd0, 1'b0, 16'h0001, 1'b1, 8'd0},
        '{1'b1, pdr_pkg::REG_RELAY_MODE, 8'd3, 1'b0, 16'h0, 1'b0, 8'd0},
        '{1'b1, pdr_pkg::REG_HUM_HYST,   8'd3, 1'b0, 16'h0, 1'b0, 8'd0},
        // heater on-off relay
        '{1'b0, 3'd0, 8'd0, 1'b0, 16'h0001, 1'b1, 8'(FULL)},
        '{1'b0, 3'd0, 8'd0, 1'b0, 16'h0000, 1'b1, 8'd0},
        '{1'b0, 3'd0, 8'd0, 1'b0, 16'h8000, 1'b1, 8'd0},
        '{1'b0, 3'd0, 8'd0, 1'b0, 16'h7FFF, 1'b1, 8'(FULL)},
        // humidifier relay: band holds the latch
        '{1'b0, 3'd0, 8'd0, 1'b1, 16'h0003, 1'b1, 8'd0},
        '{1'b0, 3'd0, 8'd0, 1'b1, 16'h0004, 1'b1, 8'(FULL)},
        '{1'b0, 3'd0, 8'd0, 1'b1, 16'h0000, 1'b1, 8'(FULL)},
        '{1'b0, 3'd0, 8'd0, 1'b1, 16'h0003, 1'b1, 8'(FULL)},
        '{1'b0, 3'd0, 8'd0, 1'b1, 16'hFFFF, 1'b1, 8'd0},
        '{1'b0, 3'd0, 8'd0, 1'b1, 16'h0002, 1'b1, 8'd0},
        '{1'b0, 3'd0, 8'd0, 1'b1, 16'h7FFF, 1'b1, 8'(FULL)},
        '{1'b0, 3'd0, 8'd0, 1'b1, 16'h8000, 1'b1, 8'd0},
        // PI mode, zero heater divisor, unmapped register
        '{1'b1, pdr_pkg::REG_RELAY_MODE,  8'd0,   1'b0, 16'h0, 1'b0, 8'd0},
        '{1'b1, pdr_pkg::REG_HUM_HYST,    8'd0,   1'b0, 16'h0, 1'b0, 8'd0},
        '{1'b1, pdr_pkg::REG_P_GAIN_HEAT, 8'd255, 1'b0, 16'h0, 1'b0, 8'd0},
        '{1'b1, pdr_pkg::REG_I_DIV_HEAT,  8'd0,   1'b0, 16'h0, 1'b0, 8'd0},
        '{1'b1, pdr_pkg::REG_P_GAIN_HUM,  8'd1,   1'b0, 16'h0, 1'b0, 8'd0},
        '{1'b1, pdr_pkg::REG_I_DIV_HUM,   8'd255, 1'b0, 16'h0, 1'b0, 8'd0},
        '{1'b1, REG_UNMAPPED,             8'd255, 1'b0, 16'h0, 1'b0, 8'd0},
        '{1'b0, 3'd0, 8'd0, 1'b0, 16'h7FFF, 1'b0, 8'd0},
        '{1'b0, 3'd0, 8'd0, 1'b0, 16'h7FFF, 1'b0, 8'd0},
        '{1'b0, 3'd0, 8'd0, 1'b0, 16'h8000, 1'b0, 8'd0},
        '{1'b0, 3'd0, 8'd0, 1'b0, 16'h8000, 1'b0, 8'd0},
        '{1'b0, 3'd0, 8'd0, 1'b1, 16'h0001, 1'b0, 8'd0},
        '{1'b0, 3'd0, 8'd0, 1'b1, 16'h7FFF, 1'b0, 8'd0},
        '{1'b0, 3'd0, 8'd0, 1'b1, 16'h8000, 1'b0, 8'd0},
        '{1'b0, 3'd0, 8'd0, 1'b0, 16'h0005, 1'b0, 8'd0},
        '{1'b0, 3'd0, 8'd0, 1'b1, 16'h0000, 1'b0, 8'd0},
        '{1'b0, 3'd0, 8'd0, 1'b0, 16'hFFFF, 1'b0, 8'd0}
    };

    pi_drive_with_relay_modes_core #(
        .FULL_DRIVE (FULL)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #4 clk = ~clk;

    task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
        $display("[%0t] mismatch %s: got %0d expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    // PI step of one channel; updates that channel's integral
    function automatic logic [7:0] pi_drive(bit ch, longint e, logic [7:0] g8, logic [7:0] d8);
        longint gain;
        longint dsr;
        longint prop;
        longint step;
        longint sum;
        gain = longint'(g8);
        dsr  = (d8 == 8'd0) ? 10 : longint'(d8) * 10;
        prop = e * gain;
        if (prop < 0)
            prop = 0;
        else if (prop > FULL)
            prop = FULL;
        prop = prop * 65536;
        step = (gain * e * 65536) / dsr;
        sum = prop + integ[ch] + step;
        if (sum < 0)
            sum = 0;
        else if (sum > longint'(FULL) * 65536)
            sum = longint'(FULL) * 65536;
        integ[ch] = sum - prop;
        return 8'(sum >>> 16);
    endfunction

    function automatic logic [7:0] predict_drive(bit ch, logic signed [15:0] e16);
        longint e;
        e = e16;
        if (ch == 1'b0)
        begin
            if (relay_mode[0])
                return (e > 0) ? 8'(FULL) : 8'd0;
            return pi_drive(1'b0, e, gain_heat, div_heat);
        end
        if (relay_mode[1])
        begin
            if (e > longint'(hum_hyst))
                hum_latch = 1'b1;
            else if (e < 0)
                hum_latch = 1'b0;
            return hum_latch ? 8'(FULL) : 8'd0;
        end
        return pi_drive(1'b1, e, gain_hum, div_hum);
    endfunction

    task automatic apb_write(logic [2:0] idx, logic [7:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'd0, val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            pdr_pkg::REG_RELAY_MODE:  relay_mode = val[1:0];
            pdr_pkg::REG_HUM_HYST:    hum_hyst   = val[1:0];
            pdr_pkg::REG_P_GAIN_HEAT: gain_heat  = val;
            pdr_pkg::REG_I_DIV_HEAT:  div_heat   = val;
            pdr_pkg::REG_P_GAIN_HUM:  gain_hum   = val;
            pdr_pkg::REG_I_DIV_HUM:   div_hum    = val;
            default: ;
        endcase
    endtask

    // drop valid and let every pending drive item come back
    task automatic drain;
        s_tvalid <= 1'b0;
        while (expected_drive_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic send_item(bit ch, logic [15:0] e, bit known, logic [7:0] drive);
        int gap;
        logic [7:0] pred;
        gap = src_idle ? $urandom_range(0, 19) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= ch;
        s_tdata  <= e;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pred = predict_drive(ch, e);
        expected_drive_q.push_back(known ? drive : pred);
    endtask

    function automatic logic [15:0] pick_err();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return 16'($signed($urandom_range(0, 600)) - 300);
            4, 5:       return 16'($signed($urandom_range(0, 5)) - 1);
            6:
            begin
                case ($urandom_range(0, 4))
                    0: return 16'h7FFF;
                    1: return 16'h8000;
                    2: return 16'h0000;
                    3: return 16'h0001;
                    default: return 16'hFFFF;
                endcase
            end
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] pick_byte(logic [7:0] lo);
        case ($urandom_range(0, 3))
            0: return lo;
            1: return 8'd255;
            2: return 8'($urandom_range(0, 15));
            default: return 8'($urandom);
        endcase
    endfunction

    // receiver: random stall per item, then check against the oldest expectation
    initial
    begin
        int stall;
        logic [7:0] want;
        wait (rst_n);
        forever
        begin
            stall = snk_idle ? $urandom_range(0, 19) : 0;
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
            if (expected_drive_q.size() == 0)
            begin
                report_mismatch("unexpected item", m_tdata, 8'd0);
            end
            else
            begin
                want = expected_drive_q.pop_front();
                if (m_tdata !== want)
                    report_mismatch("drive", m_tdata, want);
            end
        end
    end

    initial
    begin
        #2ms;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        relay_mode = 2'd0;
        hum_hyst   = 2'd0;
        gain_heat  = 8'd0;
        div_heat   = 8'd1;
        gain_hum   = 8'd0;
        div_hum    = 8'd1;
        integ[0]   = 0;
        integ[1]   = 0;
        hum_latch  = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_steps[i])
        begin
            if (directed_steps[i].cfg)
            begin
                drain();
                apb_write(directed_steps[i].idx, directed_steps[i].val);
            end
            else
            begin
                send_item(directed_steps[i].ch, directed_steps[i].err,
                          directed_steps[i].known, directed_steps[i].drive);
            end
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain();
            // cycle through all four relay settings
            apb_write(pdr_pkg::REG_RELAY_MODE, 8'(ph % 4));
            apb_write(pdr_pkg::REG_HUM_HYST, 8'($urandom_range(0, 3)));
            apb_write(pdr_pkg::REG_P_GAIN_HEAT, pick_byte(8'd0));
            apb_write(pdr_pkg::REG_I_DIV_HEAT, pick_byte(8'd1));
            apb_write(pdr_pkg::REG_P_GAIN_HUM, pick_byte(8'd0));
            apb_write(pdr_pkg::REG_I_DIV_HUM, pick_byte(8'd0));
            if ($urandom_range(0, 3) == 0)
                apb_write(REG_UNMAPPED + 3'($urandom_range(0, 1)), 8'($urandom));
            // keep one phase free of idle cycles on both sides
            src_idle = (ph != 2) && ($urandom_range(0, 3) != 0);
            snk_idle = (ph != 2) && ($urandom_range(0, 3) != 0);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send_item(1'($urandom), pick_err(), 1'b0, 8'd0);
        end

        drain();
        repeat (END_WAIT) @(posedge clk);
        if (errors == 0 && expected_drive_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl
rtl/pdr_pkg.sv
rtl/pi_drive_with_relay_modes_core.sv
rtl/pdr_checker.sv
dv/pi_drive_with_relay_modes_core_tb.sv
